// ===== sv/sitt_pkg.sv =====
// ----------------------------------------------------------------------------
// sitt_pkg
// Shared types and constants of the staggered isometric screen-to-tile picker.
// ----------------------------------------------------------------------------
package sitt_pkg;

    // Datapath widths.
    localparam int WX_W     = 18;   // world coordinate relative to the reference point
    localparam int MAG_W    = 17;   // magnitude of a world coordinate
    localparam int DIM_W    = 7;    // tile width and height
    localparam int ROWS_W   = 11;   // map_rows register
    localparam int ROW_W    = 10;   // result row
    localparam int COL_W    = 17;   // result column
    localparam int CODE_W   = 3;    // region code
    localparam int IDX_W    = 12;   // entry_index field
    localparam int ADDR_W   = 17;   // common table address before the range check
    localparam int CFG_AW   = 5;    // APB address
    localparam int CFG_DW   = 32;   // APB data

    // Commands.
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_MAP   = 1'b1;

    // Region codes stored in the mouse map.
    localparam logic [CODE_W-1:0] REG_CENTER = 3'd0;
    localparam logic [CODE_W-1:0] REG_NW     = 3'd1;
    localparam logic [CODE_W-1:0] REG_NE     = 3'd2;
    localparam logic [CODE_W-1:0] REG_SW     = 3'd3;
    localparam logic [CODE_W-1:0] REG_SE     = 3'd4;

    // Configuration register indexes (byte address is four times the index).
    localparam logic [2:0] CFG_TILE_WIDTH  = 3'd0;
    localparam logic [2:0] CFG_TILE_HEIGHT = 3'd1;
    localparam logic [2:0] CFG_REF_X       = 3'd2;
    localparam logic [2:0] CFG_REF_Y       = 3'd3;
    localparam logic [2:0] CFG_MAP_ROWS    = 3'd4;

    // Reset values.
    localparam logic [DIM_W-1:0]  RST_TILE_WIDTH  = 7'd64;
    localparam logic [DIM_W-1:0]  RST_TILE_HEIGHT = 7'd32;
    localparam logic [ROWS_W-1:0] RST_MAP_ROWS    = 11'd40;

    // Largest row count that still fits the row field.
    localparam logic [ROWS_W-1:0] ROWS_LIMIT = 11'd1024;

    // Result queue.
    localparam int FIFO_DEPTH = 32;
    localparam int FIFO_PTR_W = 5;
    localparam int FIFO_CNT_W = 6;

    // Side information that travels with an item through the divider.
    typedef struct packed {
        logic              cmd;
        logic [IDX_W-1:0]  idx;
        logic [CODE_W-1:0] value;
    } t_side;

    // One result transfer.
    typedef struct packed {
        logic             write_ack;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
    } t_result;

endpackage

// ===== sv/sitt_floor_div.sv =====
// ----------------------------------------------------------------------------
// sitt_floor_div
// Two-lane pipelined floor divider: one quotient bit per stage for x and y.
// ----------------------------------------------------------------------------
module sitt_floor_div (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    input  sitt_pkg::t_side                      i_side,
    input  logic signed [sitt_pkg::WX_W-1:0]     i_wx,
    input  logic signed [sitt_pkg::WX_W-1:0]     i_wy,
    input  logic        [sitt_pkg::DIM_W-1:0]    i_w,
    input  logic        [sitt_pkg::DIM_W-1:0]    i_h,
    output logic                                 o_valid,
    output sitt_pkg::t_side                      o_side,
    output logic signed [sitt_pkg::WX_W-1:0]     o_qx,
    output logic signed [sitt_pkg::WX_W-1:0]     o_qy,
    output logic        [sitt_pkg::DIM_W-1:0]    o_rx,
    output logic        [sitt_pkg::DIM_W-1:0]    o_ry
);
    import sitt_pkg::*;

    // One lane of the restoring divider: sign, partial remainder, and a
    // register that shifts dividend bits out and quotient bits in.
    typedef struct packed {
        logic             neg;
        logic [DIM_W-1:0] rem;
        logic [MAG_W-1:0] qn;
    } t_lane;

    logic  r_valid [0:MAG_W];
    t_side r_side  [0:MAG_W];
    t_lane r_lx    [0:MAG_W];
    t_lane r_ly    [0:MAG_W];

    logic                    r_out_valid;
    t_side                   r_out_side;
    logic signed [WX_W-1:0]  r_qx;
    logic signed [WX_W-1:0]  r_qy;
    logic [DIM_W-1:0]        r_rx;
    logic [DIM_W-1:0]        r_ry;

    logic signed [WX_W-1:0]  n_qx;
    logic signed [WX_W-1:0]  n_qy;
    logic [DIM_W-1:0]        n_rx;
    logic [DIM_W-1:0]        n_ry;

    // Split a signed value into sign and magnitude.
    function automatic t_lane lane_init(logic [WX_W-1:0] v);
        logic [WX_W-1:0] m;
        t_lane           a;
        m      = v[WX_W-1] ? (~v + 1'b1) : v;
        a.neg  = v[WX_W-1];
        a.rem  = '0;
        a.qn   = m[MAG_W-1:0];
        return a;
    endfunction

    // One restoring step: bring down the next dividend bit and subtract.
    function automatic t_lane div_step(t_lane a, logic [DIM_W-1:0] d);
        logic [DIM_W:0] t;
        t_lane          b;
        b    = a;
        t    = {a.rem, a.qn[MAG_W-1]};
        b.qn = {a.qn[MAG_W-2:0], 1'b0};
        if (t >= {1'b0, d}) begin
            t       = t - {1'b0, d};
            b.qn[0] = 1'b1;
        end
        b.rem = t[DIM_W-1:0];
        return b;
    endfunction

    // Turn a truncated result into a floor result with a non-negative remainder.
    function automatic logic [WX_W+DIM_W-1:0] floor_fix(t_lane a, logic [DIM_W-1:0] d);
        logic [WX_W-1:0]  q;
        logic [DIM_W-1:0] r;
        q = {1'b0, a.qn};
        r = a.rem;
        if (a.neg) begin
            if (a.rem != '0) begin
                q = ~q;
                r = d - a.rem;
            end else begin
                q = ~q + 1'b1;
            end
        end
        return {q, r};
    endfunction

    // Valid bits of the stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= MAG_W; k++) begin
                r_valid[k] <= 1'b0;
            end
            r_out_valid <= 1'b0;
        end else begin
            r_valid[0] <= i_valid;
            for (int k = 0; k < MAG_W; k++) begin
                r_valid[k+1] <= r_valid[k];
            end
            r_out_valid <= r_valid[MAG_W];
        end
    end

    // Stage payloads: sign split, then one quotient bit per stage.
    always_ff @(posedge i_clk) begin
        r_side[0] <= i_side;
        r_lx[0]   <= lane_init(i_wx);
        r_ly[0]   <= lane_init(i_wy);
        for (int k = 0; k < MAG_W; k++) begin
            r_side[k+1] <= r_side[k];
            r_lx[k+1]   <= div_step(r_lx[k], i_w);
            r_ly[k+1]   <= div_step(r_ly[k], i_h);
        end
    end

    // Floor correction of the last stage.
    always_comb begin
        {n_qx, n_rx} = floor_fix(r_lx[MAG_W], i_w);
        {n_qy, n_ry} = floor_fix(r_ly[MAG_W], i_h);
    end

    always_ff @(posedge i_clk) begin
        r_out_side <= r_side[MAG_W];
        r_qx       <= n_qx;
        r_qy       <= n_qy;
        r_rx       <= n_rx;
        r_ry       <= n_ry;
    end

    assign o_valid = r_out_valid;
    assign o_side  = r_out_side;
    assign o_qx    = r_qx;
    assign o_qy    = r_qy;
    assign o_rx    = r_rx;
    assign o_ry    = r_ry;

    // A map lookup always leaves remainders below the divisors.
    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_side.cmd == CMD_MAP) |-> (o_rx < i_w && o_ry < i_h))
        else $error("floor remainder not below divisor");

endmodule

// ===== sv/sitt_region_mem.sv =====
// ----------------------------------------------------------------------------
// sitt_region_mem
// Mouse-map region table: one port, write or registered read each cycle.
// ----------------------------------------------------------------------------
module sitt_region_mem #(
    parameter int DEPTH     = 4096,
    parameter int ADDR_BITS = $clog2(DEPTH)
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic                          i_we,
    input  logic [ADDR_BITS-1:0]          i_addr,
    input  logic [sitt_pkg::CODE_W-1:0]   i_wdata,
    output logic [sitt_pkg::CODE_W-1:0]   o_rdata
);
    import sitt_pkg::*;

    logic [CODE_W-1:0] r_mem [0:DEPTH-1];
    logic [CODE_W-1:0] r_rdata;

    // Items reach this port in order, so a read always sees earlier writes.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/sitt_out_fifo.sv =====
// ----------------------------------------------------------------------------
// sitt_out_fifo
// Result queue that parts the pipeline from the output handshake.
// ----------------------------------------------------------------------------
module sitt_out_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  sitt_pkg::t_result i_data,
    input  logic              i_pop,
    output logic              o_valid,
    output sitt_pkg::t_result o_data
);
    import sitt_pkg::*;

    t_result                r_mem [0:FIFO_DEPTH-1];
    logic [FIFO_PTR_W-1:0]  r_wr_ptr;
    logic [FIFO_PTR_W-1:0]  r_rd_ptr;
    logic [FIFO_CNT_W-1:0]  r_count;

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    // The credit scheme upstream must never overrun the queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |-> (r_count != FIFO_CNT_W'(FIFO_DEPTH)))
        else $error("result queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("result queue underflow");

endmodule

// ===== sv/staggered_iso_screen_to_tile.sv =====
// ----------------------------------------------------------------------------
// staggered_iso_screen_to_tile
// Maps a screen pixel to a staggered isometric tile through a mouse-map table.
//
//  Channel  | Direction | Handshake          | Payload
//  ---------+-----------+--------------------+----------------------------------
//  input    | in        | i_valid / o_ready  | command, mouse, anchor, entry
//  result   | out       | o_valid / i_ready  | write_ack, tile_col, tile_row
//  config   | in        | APB psel/penable   | tile size, reference, map rows
//
//  One transfer is accepted per cycle; each passes the input stage, the floor
//  divider in front of the table port, the address stage and the table read.
//  A queue of 32 results and a credit count keep o_ready high while fewer
//  than 32 items are in flight or waiting, so output stalls only back up
//  the input once 32 items are outstanding. Reset is synchronous and active low;
//  the table has no reset and needs no clearing pass.
// ----------------------------------------------------------------------------
module staggered_iso_screen_to_tile #(
    parameter int TABLE_DEPTH = 4096
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Input channel.
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic                             i_command,
    input  logic [15:0]                      i_mouse_x,
    input  logic [15:0]                      i_mouse_y,
    input  logic signed [15:0]               i_anchor_x,
    input  logic signed [15:0]               i_anchor_y,
    input  logic [sitt_pkg::IDX_W-1:0]       i_entry_index,
    input  logic [sitt_pkg::CODE_W-1:0]      i_entry_value,
    // Result channel.
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic                             o_write_ack,
    output logic [sitt_pkg::COL_W-1:0]       o_tile_col,
    output logic [sitt_pkg::ROW_W-1:0]       o_tile_row,
    // Configuration port.
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [sitt_pkg::CFG_AW-1:0]      paddr,
    input  logic [sitt_pkg::CFG_DW-1:0]      pwdata,
    output logic [sitt_pkg::CFG_DW-1:0]      prdata,
    output logic                             pready
);
    import sitt_pkg::*;

    localparam int TAB_AW = $clog2(TABLE_DEPTH);

    // Configuration registers.
    logic [DIM_W-1:0]         r_tile_width;
    logic [DIM_W-1:0]         r_tile_height;
    logic signed [15:0]       r_ref_x;
    logic signed [15:0]       r_ref_y;
    logic [ROWS_W-1:0]        r_map_rows;

    logic                     w_cfg_wr;
    logic [DIM_W-1:0]         w_w;
    logic [DIM_W-1:0]         w_h;
    logic [ROW_W-1:0]         w_rmax;
    logic [ROWS_W-1:0]        w_rows;

    // Handshake and credits.
    logic                     w_accept;
    logic                     w_pop;
    logic [FIFO_CNT_W-1:0]    r_outstanding;

    // Input stage.
    logic                     r_s0_valid;
    t_side                    r_s0_side;
    logic signed [WX_W-1:0]   r_s0_wx;
    logic signed [WX_W-1:0]   r_s0_wy;

    // Divider outputs.
    logic                     w_div_valid;
    t_side                    w_div_side;
    logic signed [WX_W-1:0]   w_qx;
    logic signed [WX_W-1:0]   w_qy;
    logic [DIM_W-1:0]         w_rx;
    logic [DIM_W-1:0]         w_ry;

    // Address stage.
    logic [2*DIM_W-1:0]       w_prod;
    logic [ADDR_W-1:0]        w_addr;
    logic                     r_s1_valid;
    logic                     r_s1_cmd;
    logic                     r_s1_hit;
    logic [TAB_AW-1:0]        r_s1_addr;
    logic [CODE_W-1:0]        r_s1_wdata;
    logic signed [WX_W-1:0]   r_s1_col;
    logic signed [WX_W:0]     r_s1_row;

    // Table read stage.
    logic [CODE_W-1:0]        w_rdata;
    logic                     r_s2_valid;
    logic                     r_s2_cmd;
    logic                     r_s2_hit;
    logic signed [WX_W-1:0]   r_s2_col;
    logic signed [WX_W:0]     r_s2_row;

    // Adjust and clamp.
    logic [CODE_W-1:0]        w_code;
    logic signed [WX_W:0]     w_col_adj;
    logic signed [WX_W+1:0]   w_row_adj;
    t_result                  w_result;
    t_result                  w_out;

    // ------------------------------------------------------------------
    // Configuration port.
    // ------------------------------------------------------------------
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign pready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tile_width  <= RST_TILE_WIDTH;
            r_tile_height <= RST_TILE_HEIGHT;
            r_ref_x       <= '0;
            r_ref_y       <= '0;
            r_map_rows    <= RST_MAP_ROWS;
        end else if (w_cfg_wr) begin
            case (paddr[CFG_AW-1:2])
                CFG_TILE_WIDTH:  r_tile_width  <= pwdata[DIM_W-1:0];
                CFG_TILE_HEIGHT: r_tile_height <= pwdata[DIM_W-1:0];
                CFG_REF_X:       r_ref_x       <= pwdata[15:0];
                CFG_REF_Y:       r_ref_y       <= pwdata[15:0];
                CFG_MAP_ROWS:    r_map_rows    <= pwdata[ROWS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[CFG_AW-1:2])
            CFG_TILE_WIDTH:  prdata = CFG_DW'(r_tile_width);
            CFG_TILE_HEIGHT: prdata = CFG_DW'(r_tile_height);
            CFG_REF_X:       prdata = CFG_DW'($unsigned(r_ref_x));
            CFG_REF_Y:       prdata = CFG_DW'($unsigned(r_ref_y));
            CFG_MAP_ROWS:    prdata = CFG_DW'(r_map_rows);
            default:         prdata = '0;
        endcase
    end

    // Effective tile size and last usable row.
    always_comb begin
        w_w = (r_tile_width  == '0) ? DIM_W'(1) : r_tile_width;
        w_h = (r_tile_height == '0) ? DIM_W'(1) : r_tile_height;
        if (r_map_rows == '0) begin
            w_rows = ROWS_W'(1);
        end else if (r_map_rows > ROWS_LIMIT) begin
            w_rows = ROWS_LIMIT;
        end else begin
            w_rows = r_map_rows;
        end
        w_rmax = ROW_W'(w_rows - 1'b1);
    end

    // ------------------------------------------------------------------
    // Input handshake and credit count of items in flight or queued.
    // ------------------------------------------------------------------
    assign o_ready  = (r_outstanding < FIFO_CNT_W'(FIFO_DEPTH));
    assign w_accept = i_valid && o_ready;
    assign w_pop    = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outstanding <= '0;
        end else if (w_accept && !w_pop) begin
            r_outstanding <= r_outstanding + 1'b1;
        end else if (!w_accept && w_pop) begin
            r_outstanding <= r_outstanding - 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Input stage: world position relative to the reference point.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else begin
            r_s0_valid <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s0_side.cmd   <= i_command;
        r_s0_side.idx   <= i_entry_index;
        r_s0_side.value <= i_entry_value;
        r_s0_wx <= $signed({2'b00, i_mouse_x}) + WX_W'(i_anchor_x) - WX_W'(r_ref_x);
        r_s0_wy <= $signed({2'b00, i_mouse_y}) + WX_W'(i_anchor_y) - WX_W'(r_ref_y);
    end

    // ------------------------------------------------------------------
    // Floor division into coarse cell and fine offset.
    // ------------------------------------------------------------------
    sitt_floor_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s0_valid),
        .i_side  (r_s0_side),
        .i_wx    (r_s0_wx),
        .i_wy    (r_s0_wy),
        .i_w     (w_w),
        .i_h     (w_h),
        .o_valid (w_div_valid),
        .o_side  (w_div_side),
        .o_qx    (w_qx),
        .o_qy    (w_qy),
        .o_rx    (w_rx),
        .o_ry    (w_ry)
    );

    // ------------------------------------------------------------------
    // Address stage: table address of the fine offset, or the write index.
    // ------------------------------------------------------------------
    assign w_prod = {{DIM_W{1'b0}}, w_ry} * {{DIM_W{1'b0}}, w_w};
    assign w_addr = (w_div_side.cmd == CMD_WRITE) ? ADDR_W'(w_div_side.idx)
                                                  : ADDR_W'(w_rx) + ADDR_W'(w_prod);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_div_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_cmd   <= w_div_side.cmd;
        r_s1_hit   <= (w_addr < ADDR_W'(TABLE_DEPTH));
        r_s1_addr  <= w_addr[TAB_AW-1:0];
        r_s1_wdata <= w_div_side.value;
        r_s1_col   <= w_qx;
        r_s1_row   <= {w_qy, 1'b0};
    end

    // ------------------------------------------------------------------
    // Region table.
    // ------------------------------------------------------------------
    sitt_region_mem #(
        .DEPTH     (TABLE_DEPTH),
        .ADDR_BITS (TAB_AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_en    (r_s1_valid && r_s1_hit),
        .i_we    (r_s1_cmd == CMD_WRITE),
        .i_addr  (r_s1_addr),
        .i_wdata (r_s1_wdata),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_cmd <= r_s1_cmd;
        r_s2_hit <= r_s1_hit;
        r_s2_col <= r_s1_col;
        r_s2_row <= r_s1_row;
    end

    // ------------------------------------------------------------------
    // Region adjustment and clamping, then into the result queue.
    // ------------------------------------------------------------------
    always_comb begin
        w_code    = r_s2_hit ? w_rdata : REG_CENTER;
        w_col_adj = {r_s2_col[WX_W-1], r_s2_col};
        w_row_adj = {r_s2_row[WX_W], r_s2_row};
        case (w_code)
            REG_NW: begin
                w_col_adj = w_col_adj - 2'sb01;
                w_row_adj = w_row_adj - 2'sb01;
            end
            REG_NE: begin
                w_row_adj = w_row_adj - 2'sb01;
            end
            REG_SW: begin
                w_col_adj = w_col_adj - 2'sb01;
                w_row_adj = w_row_adj + 2'sb01;
            end
            REG_SE: begin
                w_row_adj = w_row_adj + 2'sb01;
            end
            default: begin
            end
        endcase

        if (r_s2_cmd == CMD_WRITE) begin
            w_result.write_ack = 1'b1;
            w_result.col       = '0;
            w_result.row       = '0;
        end else begin
            w_result.write_ack = 1'b0;
            w_result.col = w_col_adj[WX_W] ? '0 : w_col_adj[COL_W-1:0];
            if (w_row_adj[WX_W+1]) begin
                w_result.row = '0;
            end else if ($unsigned(w_row_adj) > (WX_W+2)'(w_rmax)) begin
                w_result.row = w_rmax;
            end else begin
                w_result.row = w_row_adj[ROW_W-1:0];
            end
        end
    end

    sitt_out_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_s2_valid),
        .i_data  (w_result),
        .i_pop   (w_pop),
        .o_valid (o_valid),
        .o_data  (w_out)
    );

    assign o_write_ack = w_out.write_ack;
    assign o_tile_col  = w_out.col;
    assign o_tile_row  = w_out.row;

    // ------------------------------------------------------------------
    // Checks.
    // ------------------------------------------------------------------
    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_outstanding <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("credit count above queue depth");

    a_result_has_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_outstanding != '0))
        else $error("result without an item in flight");

    a_write_answer_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_write_ack) |-> (o_tile_col == '0 && o_tile_row == '0))
        else $error("write answer carries a tile");

    a_row_in_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && r_s2_cmd == CMD_MAP) |-> (w_result.row <= w_rmax))
        else $error("row beyond last map row");

endmodule
